FILE: src/mops_pkg.sv
// ----------------------------------------------------------------------------
// mops_pkg
// Shared types, codes and defaults of the Morton order point sorter.
// ----------------------------------------------------------------------------
package mops_pkg;

	localparam int MAX_POINTS_DEF = 4096;
	localparam int BITS_DEF = 21;
	localparam int COORD_W = 32;
	localparam int CODE_OUT_W = 63;
	localparam int INDEX_OUT_W = 12;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_FETCH = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic signed [COORD_W-1:0] x_pos;
		logic signed [COORD_W-1:0] y_pos;
		logic signed [COORD_W-1:0] z_pos;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [CODE_OUT_W-1:0] morton_code;
		logic [INDEX_OUT_W-1:0] point_index;
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic last_entry;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic q_init;
		logic q_prep;
		logic q_load;
		logic q_step;
		logic q_wr;
		logic m_init;
		logic m_done;
		logic m_pass_start;
		logic m_pass_end;
		logic m_run_start;
		logic m_run_end;
		logic m_rda;
		logic m_rdb;
		logic m_wr;
		logic f_empty;
		logic f_rd1;
		logic f_rd2;
		logic f_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic sorted;
		logic fetch_empty;
		logic q_more;
		logic div_done;
		logic pass_more;
		logic run_more;
		logic elem_more;
	} sts_t;

endpackage

FILE: src/morton_order_point_sorter.sv
// ----------------------------------------------------------------------------
// morton_order_point_sorter
// Loads signed Q16.16 points, quantizes them against their bounding box,
// sorts them by 3D Morton code and streams them out in code order.
// ----------------------------------------------------------------------------
// A load, clear or unused command is taken from idle and its response is
// registered at once. The first fetch after a load runs the sort pass: the
// n points are quantized by the bit-serial divider lanes, then sorted in
// ceil(log2 n) merge passes, each reading both runs through the single read
// port of the record banks. Every later fetch does two dependent memory
// reads. Clearing resets only the counters, the sorted flag and the bounding
// box; stored points are never read before being written.
module morton_order_point_sorter #(
	parameter int MAX_POINTS = mops_pkg::MAX_POINTS_DEF,
	parameter int BITS_PER_AXIS = mops_pkg::BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  mops_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output mops_pkg::rsp_t rsp
);
	import mops_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mops_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_func(req.func),
		.req_ready(req_ready),
		.sts(sts),
		.cmd(cmd)
	);

	mops_dp #(
		.MAX_POINTS(MAX_POINTS),
		.BITS_PER_AXIS(BITS_PER_AXIS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd(cmd),
		.sts(sts),
		.rsp(rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

endmodule

FILE: src/mops_ram.sv
// ----------------------------------------------------------------------------
// mops_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mops_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/mops_ctrl.sv
// ----------------------------------------------------------------------------
// mops_ctrl
// Sequencer for load, quantize, merge sort and fetch of the point sorter.
// ----------------------------------------------------------------------------
module mops_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic [1:0] req_func,
	output logic req_ready,
	input  mops_pkg::sts_t sts,
	output mops_pkg::cmd_t cmd
);
	import mops_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_Q_CHK  = 14'b00000000000010,
		S_Q_RD   = 14'b00000000000100,
		S_Q_PREP = 14'b00000000001000,
		S_Q_LOAD = 14'b00000000010000,
		S_Q_DIV  = 14'b00000000100000,
		S_M_PASS = 14'b00000001000000,
		S_M_RUN  = 14'b00000010000000,
		S_M_RDA  = 14'b00000100000000,
		S_M_RDB  = 14'b00001000000000,
		S_M_WR   = 14'b00010000000000,
		S_F_CHK  = 14'b00100000000000,
		S_F_RD2  = 14'b01000000000000,
		S_F_OUT  = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic take;

	assign req_ready = (state_q == S_IDLE) && sts.out_free;
	assign take = req_ready && req_valid;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					if (req_func == FUNC_FETCH) begin
						if (sts.sorted) begin
							state_d = S_F_CHK;
						end else begin
							cmd.q_init = 1'b1;
							state_d = S_Q_CHK;
						end
					end else begin
						cmd.accept = 1'b1;
					end
				end
			end
			S_Q_CHK: begin
				if (sts.q_more) begin
					state_d = S_Q_RD;
				end else begin
					cmd.m_init = 1'b1;
					state_d = S_M_PASS;
				end
			end
			S_Q_RD: state_d = S_Q_PREP;
			S_Q_PREP: begin
				cmd.q_prep = 1'b1;
				state_d = S_Q_LOAD;
			end
			S_Q_LOAD: begin
				cmd.q_load = 1'b1;
				state_d = S_Q_DIV;
			end
			S_Q_DIV: begin
				if (sts.div_done) begin
					cmd.q_wr = 1'b1;
					state_d = S_Q_CHK;
				end else begin
					cmd.q_step = 1'b1;
				end
			end
			S_M_PASS: begin
				if (sts.pass_more) begin
					cmd.m_pass_start = 1'b1;
					state_d = S_M_RUN;
				end else begin
					cmd.m_done = 1'b1;
					state_d = S_F_CHK;
				end
			end
			S_M_RUN: begin
				if (sts.run_more) begin
					cmd.m_run_start = 1'b1;
					state_d = S_M_RDA;
				end else begin
					cmd.m_pass_end = 1'b1;
					state_d = S_M_PASS;
				end
			end
			S_M_RDA: begin
				if (sts.elem_more) begin
					cmd.m_rda = 1'b1;
					state_d = S_M_RDB;
				end else begin
					cmd.m_run_end = 1'b1;
					state_d = S_M_RUN;
				end
			end
			S_M_RDB: begin
				cmd.m_rdb = 1'b1;
				state_d = S_M_WR;
			end
			S_M_WR: begin
				cmd.m_wr = 1'b1;
				state_d = S_M_RDA;
			end
			S_F_CHK: begin
				if (sts.fetch_empty) begin
					cmd.f_empty = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.f_rd1 = 1'b1;
					state_d = S_F_RD2;
				end
			end
			S_F_RD2: begin
				cmd.f_rd2 = 1'b1;
				state_d = S_F_OUT;
			end
			S_F_OUT: begin
				cmd.f_out = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/mops_dp.sv
// ----------------------------------------------------------------------------
// mops_dp
// Point stores, bounding box, quantizing dividers, merge banks and result
// register of the point sorter.
// ----------------------------------------------------------------------------
module mops_dp #(
	parameter int MAX_POINTS = mops_pkg::MAX_POINTS_DEF,
	parameter int BITS_PER_AXIS = mops_pkg::BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  mops_pkg::req_t req,
	input  mops_pkg::cmd_t cmd,
	output mops_pkg::sts_t sts,
	output mops_pkg::rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_ready
);
	import mops_pkg::*;

	localparam int B = BITS_PER_AXIS;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int WW = CNT_W + 1;
	localparam int CODE_W = 3 * B;
	localparam int REC_W = CODE_W + IDX_W;
	localparam int BC_W = $clog2(B + 1);
	localparam int PW = COORD_W + 1;
	localparam int DW = PW + B;
	localparam int PT_W = 3 * COORD_W;

	logic [CNT_W-1:0] cnt_q, fp_q, i_q;
	logic sorted_q;
	logic signed [COORD_W-1:0] min_q [3];
	logic signed [COORD_W-1:0] max_q [3];
	logic [PW-1:0] num_q [3];
	logic [PW-1:0] span_q [3];
	logic flat_q [3];
	logic [PW-1:0] rem_q [3];
	logic [B-1:0] dlo_q [3];
	logic [B-1:0] quo_q [3];
	logic [BC_W-1:0] bit_q;
	logic [WW-1:0] width_q, lo_q, mid_q, hi_q, a_q, b_q, k_q;
	logic src_q;
	logic [REC_W-1:0] reca_q, rec_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic full, do_load;
	logic signed [COORD_W-1:0] pin [3];
	logic signed [COORD_W-1:0] prd [3];
	logic [PT_W-1:0] pt_rd;
	logic [IDX_W-1:0] pt_raddr, bank_raddr, bank0_waddr;
	logic [REC_W-1:0] rd0, rd1, bank_rd, new_rec, pick_rec, bank0_wdata;
	logic [CODE_W-1:0] code;
	logic [B-1:0] qv [3];
	logic take_b;
	logic [WW-1:0] n_w, lo_w, mid_w, hi_w;

	assign full = (cnt_q == CNT_W'(MAX_POINTS));
	assign do_load = cmd.accept && (req.func == FUNC_LOAD) && !full;
	assign pin[0] = req.x_pos;
	assign pin[1] = req.y_pos;
	assign pin[2] = req.z_pos;
	assign prd[0] = pt_rd[3*COORD_W-1:2*COORD_W];
	assign prd[1] = pt_rd[2*COORD_W-1:COORD_W];
	assign prd[2] = pt_rd[COORD_W-1:0];

	assign pt_raddr = cmd.f_rd2 ? bank_rd[IDX_W-1:0] : i_q[IDX_W-1:0];

	mops_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk(clk),
		.we(do_load),
		.waddr(cnt_q[IDX_W-1:0]),
		.wdata({req.x_pos, req.y_pos, req.z_pos}),
		.raddr(pt_raddr),
		.rdata(pt_rd)
	);

	// morton interleave
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			qv[a] = flat_q[a] ? '0 : quo_q[a];
		end
		for (int b = 0; b < B; b++) begin
			code[3*b] = qv[0][b];
			code[3*b+1] = qv[1][b];
			code[3*b+2] = qv[2][b];
		end
	end

	assign new_rec = {code, i_q[IDX_W-1:0]};
	assign bank_rd = src_q ? rd1 : rd0;
	assign bank_raddr = cmd.f_rd1 ? fp_q[IDX_W-1:0] :
		(cmd.m_rda ? a_q[IDX_W-1:0] : b_q[IDX_W-1:0]);
	assign take_b = !(a_q < mid_q) || ((b_q < hi_q) && (bank_rd < reca_q));
	assign pick_rec = take_b ? bank_rd : reca_q;
	assign bank0_waddr = cmd.q_wr ? i_q[IDX_W-1:0] : k_q[IDX_W-1:0];
	assign bank0_wdata = cmd.q_wr ? new_rec : pick_rec;

	mops_ram #(.WIDTH(REC_W), .DEPTH(MAX_POINTS)) u_bank0 (
		.clk(clk),
		.we(cmd.q_wr || (cmd.m_wr && src_q)),
		.waddr(bank0_waddr),
		.wdata(bank0_wdata),
		.raddr(bank_raddr),
		.rdata(rd0)
	);

	mops_ram #(.WIDTH(REC_W), .DEPTH(MAX_POINTS)) u_bank1 (
		.clk(clk),
		.we(cmd.m_wr && !src_q),
		.waddr(k_q[IDX_W-1:0]),
		.wdata(pick_rec),
		.raddr(bank_raddr),
		.rdata(rd1)
	);

	assign n_w = WW'(cnt_q);
	assign lo_w = lo_q + width_q;
	assign mid_w = (lo_w < n_w) ? lo_w : n_w;
	assign hi_w = ((mid_w + width_q) < n_w) ? (mid_w + width_q) : n_w;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fp_q <= '0;
			sorted_q <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				min_q[a] <= {1'b0, {(COORD_W-1){1'b1}}};
				max_q[a] <= {1'b1, {(COORD_W-1){1'b0}}};
			end
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.accept || cmd.f_empty || cmd.f_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (do_load) begin
				for (int a = 0; a < 3; a++) begin
					if (pin[a] < min_q[a]) begin
						min_q[a] <= pin[a];
					end
					if (pin[a] > max_q[a]) begin
						max_q[a] <= pin[a];
					end
				end
				cnt_q <= cnt_q + 1'b1;
				sorted_q <= 1'b0;
				fp_q <= '0;
			end
			if (cmd.accept && (req.func == FUNC_CLEAR)) begin
				for (int a = 0; a < 3; a++) begin
					min_q[a] <= {1'b0, {(COORD_W-1){1'b1}}};
					max_q[a] <= {1'b1, {(COORD_W-1){1'b0}}};
				end
				cnt_q <= '0;
				fp_q <= '0;
				sorted_q <= 1'b0;
			end
			if (cmd.m_done) begin
				sorted_q <= 1'b1;
				fp_q <= '0;
			end
			if (cmd.f_out) begin
				fp_q <= fp_q + 1'b1;
			end
		end
	end

	// sort datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			bit_q <= '0;
			width_q <= '0;
			lo_q <= '0;
			mid_q <= '0;
			hi_q <= '0;
			a_q <= '0;
			b_q <= '0;
			k_q <= '0;
			src_q <= 1'b0;
		end else begin
			if (cmd.q_init) begin
				i_q <= '0;
			end
			if (cmd.q_wr) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.q_load) begin
				bit_q <= BC_W'(B);
			end
			if (cmd.q_step) begin
				bit_q <= bit_q - 1'b1;
			end
			if (cmd.m_init) begin
				width_q <= WW'(1);
				src_q <= 1'b0;
			end
			if (cmd.m_pass_start) begin
				lo_q <= '0;
				k_q <= '0;
			end
			if (cmd.m_pass_end) begin
				width_q <= {width_q[WW-2:0], 1'b0};
				src_q <= !src_q;
			end
			if (cmd.m_run_start) begin
				mid_q <= mid_w;
				hi_q <= hi_w;
				a_q <= lo_q;
				b_q <= mid_w;
			end
			if (cmd.m_run_end) begin
				lo_q <= lo_q + {width_q[WW-2:0], 1'b0};
			end
			if (cmd.m_wr) begin
				k_q <= k_q + 1'b1;
				if (take_b) begin
					b_q <= b_q + 1'b1;
				end else begin
					a_q <= a_q + 1'b1;
				end
			end
		end
	end

	// quantize lanes and payload registers
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			logic [PW-1:0] diff, span;
			logic [DW-1:0] prod;
			logic [PW:0] rem2;
			logic ge;
			diff = {prd[a][COORD_W-1], prd[a]} - {min_q[a][COORD_W-1], min_q[a]};
			span = {max_q[a][COORD_W-1], max_q[a]} - {min_q[a][COORD_W-1], min_q[a]};
			prod = {num_q[a], {B{1'b0}}} - DW'(num_q[a]);
			rem2 = {rem_q[a], dlo_q[a][B-1]};
			ge = (rem2 >= {1'b0, span_q[a]});
			if (cmd.q_prep) begin
				num_q[a] <= (diff > span) ? span : diff;
				span_q[a] <= span;
				flat_q[a] <= !(max_q[a] > min_q[a]);
			end
			if (cmd.q_load) begin
				rem_q[a] <= prod[DW-1:B];
				dlo_q[a] <= prod[B-1:0];
				quo_q[a] <= '0;
			end
			if (cmd.q_step) begin
				rem_q[a] <= ge ? PW'(rem2 - {1'b0, span_q[a]}) : rem2[PW-1:0];
				dlo_q[a] <= {dlo_q[a][B-2:0], 1'b0};
				quo_q[a] <= {quo_q[a][B-2:0], ge};
			end
		end
		if (cmd.m_rdb) begin
			reca_q <= bank_rd;
		end
		if (cmd.f_rd2) begin
			rec_q <= bank_rd;
		end
		if (cmd.accept) begin
			rsp_q <= '{status: (((req.func == FUNC_LOAD) && full) ? ST_FULL : ST_OK),
				default: '0};
		end
		if (cmd.f_empty) begin
			rsp_q <= '{status: ST_EMPTY, default: '0};
		end
		if (cmd.f_out) begin
			rsp_q.status <= ST_OK;
			rsp_q.morton_code <= CODE_OUT_W'(rec_q[REC_W-1:IDX_W]);
			rsp_q.point_index <= INDEX_OUT_W'(rec_q[IDX_W-1:0]);
			rsp_q.out_x <= prd[0];
			rsp_q.out_y <= prd[1];
			rsp_q.out_z <= prd[2];
			rsp_q.last_entry <= ((fp_q + 1'b1) == cnt_q);
		end
	end

	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign sts.sorted = sorted_q;
	assign sts.fetch_empty = (fp_q >= cnt_q);
	assign sts.q_more = (i_q < cnt_q);
	assign sts.div_done = (bit_q == '0);
	assign sts.pass_more = (width_q < n_w);
	assign sts.run_more = (lo_q < n_w);
	assign sts.elem_more = (k_q < hi_q);

	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule
